FILE: hdl/ocf_pkg.sv
// ----------------------------------------------------------------------------
// ocf_pkg
// types and constants shared by the original pulse channel finder
// ----------------------------------------------------------------------------
package ocf_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int IDX_BITS    = 10;
    localparam int SMP_BITS    = 12;

    localparam logic [2:0] REG_ZERO_LEVEL       = 3'd0;
    localparam logic [2:0] REG_START_AMPLITUDE  = 3'd1;
    localparam logic [2:0] REG_QUAL_LEVEL       = 3'd2;
    localparam logic [2:0] REG_LEAD_LEVEL       = 3'd3;
    localparam logic [2:0] REG_PULSE_WIDTH      = 3'd4;
    localparam logic [2:0] REG_MIN_SEPARATION   = 3'd5;
    localparam logic [2:0] REG_EDGE_JITTER      = 3'd6;
    localparam logic [2:0] REG_AMPLITUDE_JITTER = 3'd7;

    typedef enum logic [1:0] {
        Q_SEARCH,
        Q_NOPULSE,
        Q_QUAL
    } qual_state_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_RD1,
        S_EV1,
        S_RD2,
        S_EV2,
        S_EMIT
    } walk_state_t;

    typedef struct packed {
        logic [11:0] zero_level;
        logic [11:0] start_amplitude;
        logic [11:0] qual_level;
        logic [11:0] lead_level;
        logic [9:0]  pulse_width;
        logic [9:0]  min_separation;
        logic [9:0]  edge_jitter;
        logic [11:0] amplitude_jitter;
    } cfg_t;

    typedef struct packed {
        logic [4:0]  channel_number;
        logic [11:0] sample;
        logic        last_of_channel;
        logic        last_of_panel;
    } in_item_t;

    typedef struct packed {
        logic [31:0] hit_mask;
        logic [5:0]  hit_count;
        logic        decided_by_lead;
        logic [9:0]  earliest_edge;
    } out_item_t;

    // record summary handed over when a channel record closes
    typedef struct packed {
        logic                valid;
        logic [IDX_BITS-1:0] edge_idx;
        logic [SMP_BITS-1:0] minimum;
    } rec_t;

endpackage

FILE: hdl/ocf_chan_mem.sv
// ----------------------------------------------------------------------------
// ocf_chan_mem
// per-channel store of edge index and minimum, one write and one read port
// ----------------------------------------------------------------------------
module ocf_chan_mem
    import ocf_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [IDX_BITS+SMP_BITS-1:0] wdata,
    input  logic [AW-1:0]                raddr,
    output logic [IDX_BITS+SMP_BITS-1:0] rdata
);

    logic [IDX_BITS+SMP_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/ocf_record.sv
// ----------------------------------------------------------------------------
// ocf_record
// per-record pulse qualification, leading edge and windowed minimum
// ----------------------------------------------------------------------------
module ocf_record
    import ocf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                close,
    input  logic [SMP_BITS-1:0] sample,
    input  cfg_t                cfg,
    output rec_t                rec
);

    logic [IDX_BITS:0]     idx_reg, idx_next;
    qual_state_t           qs_reg, qs_next;
    logic [IDX_BITS-1:0]   fs_reg, fs_next;
    logic                  fv_reg, fv_next;
    logic                  ef_reg, ef_next;
    logic [IDX_BITS-1:0]   re_reg, re_next;
    logic [SMP_BITS-1:0]   rm_reg, rm_next;
    logic [IDX_BITS-1:0]   i;
    logic [SMP_BITS:0]     dev;
    logic                  above;

    always_comb
    begin
        idx_next = idx_reg;
        qs_next  = qs_reg;
        fs_next  = fs_reg;
        fv_next  = fv_reg;
        ef_next  = ef_reg;
        re_next  = re_reg;
        rm_next  = rm_reg;
        i        = idx_reg[IDX_BITS-1:0];
        above    = sample > cfg.zero_level;
        dev      = above ? ({1'b0, sample} - {1'b0, cfg.zero_level})
                         : ({1'b0, cfg.zero_level} - {1'b0, sample});
        if (idx_reg < (IDX_BITS+1)'(MAX_SAMPLES))
        begin
            idx_next = idx_reg + 1'b1;
            if (qs_reg == Q_SEARCH)
            begin
                if (dev > {1'b0, cfg.start_amplitude})
                begin
                    if (above)
                    begin
                        qs_next = Q_NOPULSE;
                    end
                    else
                    begin
                        fs_next = i;
                        fv_next = 1'b1;
                    end
                end
                if (qs_next == Q_SEARCH && fv_next)
                begin
                    if (sample < cfg.qual_level)
                    begin
                        qs_next = Q_QUAL;
                    end
                    else if ((i - fs_next) > cfg.pulse_width)
                    begin
                        qs_next = Q_NOPULSE;
                    end
                end
            end
            if (!ef_reg)
            begin
                if (sample < cfg.lead_level)
                begin
                    ef_next = 1'b1;
                    re_next = i;
                    rm_next = sample;
                end
            end
            else if ((i - re_reg) < cfg.pulse_width)
            begin
                if (sample < rm_reg)
                begin
                    rm_next = sample;
                end
            end
        end
        rec.valid    = (qs_next == Q_QUAL) && ef_next;
        rec.edge_idx = re_next;
        rec.minimum  = rm_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            qs_reg  <= Q_SEARCH;
            fs_reg  <= '0;
            fv_reg  <= 1'b0;
            ef_reg  <= 1'b0;
            re_reg  <= '0;
            rm_reg  <= '1;
        end
        else if (step)
        begin
            if (close)
            begin
                idx_reg <= '0;
                qs_reg  <= Q_SEARCH;
                fs_reg  <= '0;
                fv_reg  <= 1'b0;
                ef_reg  <= 1'b0;
                re_reg  <= '0;
                rm_reg  <= '1;
            end
            else
            begin
                idx_reg <= idx_next;
                qs_reg  <= qs_next;
                fs_reg  <= fs_next;
                fv_reg  <= fv_next;
                ef_reg  <= ef_next;
                re_reg  <= re_next;
                rm_reg  <= rm_next;
            end
        end
    end

endmodule

FILE: hdl/original_pulse_channel_finder_unit.sv
// ----------------------------------------------------------------------------
// original_pulse_channel_finder_unit
// finds the channels of a panel that carry the original pulse
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while busy is low. On the last sample of a
// panel busy rises: a decide state settles by edge lead, and when the edges
// bunch the block walks the channel store twice, reading each channel from
// memory and then comparing it. The result strobe is high for one cycle and
// cannot be held off; busy drops after it.
module original_pulse_channel_finder_unit
    import ocf_pkg::*;
#(
    parameter int CHANNELS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    item,
    output logic        result_valid,
    output out_item_t   result,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [11:0] wr_data
);

    localparam int NCH = (CHANNELS < 32) ? CHANNELS : 32;
    localparam int AW  = $clog2(NCH);

    cfg_t                cfg_reg;
    walk_state_t         st_reg, st_next;
    rec_t                rec;
    logic                step, close, ch_ok;
    logic [NCH-1:0]      valid_reg;
    logic                have_e_reg, have_n_reg;
    logic [IDX_BITS-1:0] e_reg, n_reg;
    logic [4:0]          e_ch_reg;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic [SMP_BITS-1:0] low_reg, low_next;
    logic [31:0]         mask_reg, mask_next;
    logic [5:0]          count_reg, count_next;
    logic                lead_reg, lead_next;
    logic [IDX_BITS+SMP_BITS-1:0] rdata;
    logic [IDX_BITS-1:0] rd_edge;
    logic [SMP_BITS-1:0] rd_min;
    logic                member;

    assign step  = start && !busy;
    assign close = item.last_of_channel || item.last_of_panel;
    assign ch_ok = {1'b0, item.channel_number} < 6'(NCH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{12'd2048, 12'd50, 12'd1800, 12'd1900,
                         10'd20, 10'd5, 10'd3, 12'd40};
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ZERO_LEVEL:       cfg_reg.zero_level       <= wr_data;
                REG_START_AMPLITUDE:  cfg_reg.start_amplitude  <= wr_data;
                REG_QUAL_LEVEL:       cfg_reg.qual_level       <= wr_data;
                REG_LEAD_LEVEL:       cfg_reg.lead_level       <= wr_data;
                REG_PULSE_WIDTH:      cfg_reg.pulse_width      <= wr_data[9:0];
                REG_MIN_SEPARATION:   cfg_reg.min_separation   <= wr_data[9:0];
                REG_EDGE_JITTER:      cfg_reg.edge_jitter      <= wr_data[9:0];
                REG_AMPLITUDE_JITTER: cfg_reg.amplitude_jitter <= wr_data;
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    ocf_record u_record (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .close  (close),
        .sample (item.sample),
        .cfg    (cfg_reg),
        .rec    (rec)
    );

    ocf_chan_mem #(.DEPTH(NCH), .AW(AW)) u_mem (
        .clk   (clk),
        .we    (step && close && ch_ok),
        .waddr (item.channel_number[AW-1:0]),
        .wdata ({rec.edge_idx, rec.minimum}),
        .raddr (cnt_reg),
        .rdata (rdata)
    );

    assign rd_edge = rdata[IDX_BITS+SMP_BITS-1:SMP_BITS];
    assign rd_min  = rdata[SMP_BITS-1:0];
    assign member  = valid_reg[cnt_reg] && ((rd_edge - e_reg) < cfg_reg.edge_jitter);

    // channel valid bits and earliest / next edge tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            have_e_reg <= 1'b0;
            have_n_reg <= 1'b0;
            e_reg      <= '0;
            n_reg      <= '0;
            e_ch_reg   <= '0;
        end
        else if (st_reg == S_EMIT)
        begin
            valid_reg  <= '0;
            have_e_reg <= 1'b0;
            have_n_reg <= 1'b0;
            e_reg      <= '0;
            n_reg      <= '0;
            e_ch_reg   <= '0;
        end
        else if (step && close && ch_ok)
        begin
            valid_reg[item.channel_number[AW-1:0]] <= rec.valid;
            if (rec.valid)
            begin
                if (!have_e_reg || rec.edge_idx <= e_reg)
                begin
                    if (have_e_reg)
                    begin
                        n_reg      <= e_reg;
                        have_n_reg <= 1'b1;
                    end
                    e_reg      <= rec.edge_idx;
                    e_ch_reg   <= item.channel_number;
                    have_e_reg <= 1'b1;
                end
                else if (!have_n_reg || rec.edge_idx < n_reg)
                begin
                    n_reg      <= rec.edge_idx;
                    have_n_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        st_next    = st_reg;
        cnt_next   = cnt_reg;
        low_next   = low_reg;
        mask_next  = mask_reg;
        count_next = count_reg;
        lead_next  = lead_reg;
        case (st_reg)
            S_IDLE:
            begin
                if (step && item.last_of_panel)
                begin
                    st_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cnt_next   = '0;
                low_next   = '1;
                mask_next  = '0;
                count_next = '0;
                lead_next  = 1'b0;
                if (!have_e_reg)
                begin
                    st_next = S_EMIT;
                end
                else if (!have_n_reg || (n_reg - e_reg) >= cfg_reg.min_separation)
                begin
                    lead_next  = 1'b1;
                    mask_next  = 32'd1 << e_ch_reg;
                    count_next = 6'd1;
                    st_next    = S_EMIT;
                end
                else
                begin
                    st_next = S_RD1;
                end
            end
            S_RD1:
            begin
                st_next = S_EV1;
            end
            S_EV1:
            begin
                if (member && rd_min < low_reg)
                begin
                    low_next = rd_min;
                end
                if (cnt_reg == AW'(NCH - 1))
                begin
                    cnt_next = '0;
                    st_next  = S_RD2;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    st_next  = S_RD1;
                end
            end
            S_RD2:
            begin
                st_next = S_EV2;
            end
            S_EV2:
            begin
                if (member && (rd_min - low_reg) <= cfg_reg.amplitude_jitter)
                begin
                    mask_next  = mask_reg | (32'd1 << cnt_reg);
                    count_next = count_reg + 1'b1;
                end
                if (cnt_reg == AW'(NCH - 1))
                begin
                    st_next = S_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    st_next  = S_RD2;
                end
            end
            S_EMIT:
            begin
                st_next = S_IDLE;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg   <= low_next;
        mask_reg  <= mask_next;
        count_reg <= count_next;
        lead_reg  <= lead_next;
    end

    assign busy                   = st_reg != S_IDLE;
    assign result_valid           = st_reg == S_EMIT;
    assign result.hit_mask        = mask_reg;
    assign result.hit_count       = count_reg;
    assign result.decided_by_lead = lead_reg;
    assign result.earliest_edge   = e_reg;

endmodule
